[rtl/kpr_pkg.sv]
// Package for the present-slot order-statistic store.
// Holds the tree geometry constants, command and unit-op codes and the unit result struct.
// No dependencies.
package kpr_pkg;

  // Number of value slots and the geometry of the count tree above them.
  localparam int LEAVES     = 1024;
  localparam int LEVELS     = $clog2(LEAVES);
  localparam int SPAN       = 1 << LEVELS;
  localparam int TREE_DEPTH = 2 * SPAN;
  localparam int TREE_AW    = LEVELS + 1;

  // Field widths of the stream payloads.
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 10;
  localparam int VALUE_W = 32;
  localparam int RANK_W  = 11;
  localparam int CNT_W   = RANK_W;
  localparam int IN_W    = 56;
  localparam int OUT_W   = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_INC  = 2'd0,
    OP_ROOT = 2'd1,
    OP_DESC = 2'd2,
    OP_IDLE = 2'd3
  } op_t;

  typedef struct packed {
    logic             err;
    logic             go_right;
    logic [CNT_W-1:0] k_nxt;
    logic [CNT_W-1:0] child_cnt;
    logic [CNT_W-1:0] wr_data;
  } alu_res_t;

endpackage

[rtl/kpr_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module kpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/kpr_alu.sv]
// Shared count unit: increment, root range check and one step of the rank descent.
// Depends on kpr_pkg.
module kpr_alu (
  input  kpr_pkg::op_t               op,
  input  logic [kpr_pkg::CNT_W-1:0]  rd_cnt,
  input  logic [kpr_pkg::CNT_W-1:0]  k,
  input  logic [kpr_pkg::CNT_W-1:0]  node_cnt,
  output kpr_pkg::alu_res_t          res
);
  import kpr_pkg::*;

  always_comb begin
    res           = '0;
    res.k_nxt     = k;
    res.child_cnt = rd_cnt;
    unique case (op)
      OP_INC: begin
        res.wr_data = rd_cnt + CNT_W'(1);
      end
      OP_ROOT: begin
        res.err     = (k == '0) || (k > rd_cnt);
        res.wr_data = rd_cnt - CNT_W'(1);
      end
      OP_DESC: begin
        // rd_cnt is the left child's count; the right child holds the rest.
        res.go_right = k > rd_cnt;
        if (res.go_right) begin
          res.k_nxt     = k - rd_cnt;
          res.child_cnt = node_cnt - rd_cnt;
        end
        res.wr_data = res.child_cnt - CNT_W'(1);
      end
      default: begin
        res.wr_data = rd_cnt;
      end
    endcase
  end

endmodule

[rtl/kth_present_remove_tree.sv]
// Top level of the present-slot order-statistic store with select-and-delete.
// Depends on kpr_pkg, kpr_ram and kpr_alu.
//
// Usage: one input stream carries commands (load a value at a slot, remove the
// k-th present slot, clear all). Only a remove transaction produces a result
// transaction on the output stream: the removed value, or zero with the error
// flag set when the rank is zero or above the number of present slots.
// The block works on one command at a time and holds in_tready low meanwhile.
// All tree counts live in one RAM, and a single count unit touches one tree
// node per cycle, so the path length of the tree sets the timing:
//   remove: root check, one descent step per tree level, value read and
//           output load (held while the output register is full), and the
//           next command can be taken once the result is offered; a rejected
//           rank skips the descent and goes straight to the output load;
//   load:   no count change when the slot is already present, otherwise
//           the counts along the path from leaf to root are raised;
//   clear:  a clearing pass that zeroes all TREE_DEPTH = 2048 count RAM entries.
// After reset the same clearing pass runs before the first transaction is taken;
// the stored values are not cleared.
// The result sits in an output register, so a new command is accepted while a
// result waits; if the receiver stalls and a second result is ready, the block
// holds that result internally and waits with in_tready low.
module kth_present_remove_tree (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // in_tdata fields from bit 0: cmd[1:0], slot[11:2], value[43:12], rank[54:44], zero pad.
  input  logic [kpr_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // out_tdata fields from bit 0: value_out[31:0], error[32], zero pad.
  output logic [kpr_pkg::OUT_W-1:0] out_tdata
);
  import kpr_pkg::*;

  typedef enum logic [7:0] {
    S_CLR   = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_LCHK  = 8'b0000_0100,
    S_LINC  = 8'b0000_1000,
    S_RROOT = 8'b0001_0000,
    S_DESC  = 8'b0010_0000,
    S_VAL   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Unpacked input fields.
  cmd_t               in_cmd;
  logic [SLOT_W-1:0]  in_slot;
  logic [VALUE_W-1:0] in_value;
  logic [RANK_W-1:0]  in_rank;

  assign in_cmd   = cmd_t'(in_tdata[1:0]);
  assign in_slot  = in_tdata[11:2];
  assign in_value = in_tdata[43:12];
  assign in_rank  = in_tdata[54:44];

  // Walk registers.
  logic [TREE_AW-1:0] node_r, node_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [TREE_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // Pending result and output stage.
  logic [VALUE_W-1:0] res_val_r, res_val_nxt;
  logic               res_err_r, res_err_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_val_r, out_val_nxt;
  logic               out_err_r, out_err_nxt;

  // Count tree RAM.
  logic               tr_we, tr_re;
  logic [TREE_AW-1:0] tr_waddr, tr_raddr;
  logic [CNT_W-1:0]   tr_wdata, tr_rdata;

  // Value store RAM.
  logic               vs_we, vs_re;
  logic [LEVELS-1:0]  vs_waddr, vs_raddr;
  logic [VALUE_W-1:0] vs_rdata;

  // Shared count unit.
  op_t                alu_op;
  alu_res_t           alu_res;
  logic [TREE_AW-1:0] child;

  logic in_acc;
  logic out_free;
  logic slot_ok;

  kpr_ram #(.WIDTH(CNT_W), .DEPTH(TREE_DEPTH)) u_tree_ram (
    .clk   (clk),
    .we    (tr_we),
    .waddr (tr_waddr),
    .wdata (tr_wdata),
    .re    (tr_re),
    .raddr (tr_raddr),
    .rdata (tr_rdata)
  );

  kpr_ram #(.WIDTH(VALUE_W), .DEPTH(LEAVES)) u_value_ram (
    .clk   (clk),
    .we    (vs_we),
    .waddr (vs_waddr),
    .wdata (in_value),
    .re    (vs_re),
    .raddr (vs_raddr),
    .rdata (vs_rdata)
  );

  kpr_alu u_alu (
    .op       (alu_op),
    .rd_cnt   (tr_rdata),
    .k        (k_r),
    .node_cnt (cnt_r),
    .res      (alu_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign slot_ok    = {{(32-SLOT_W){1'b0}}, in_slot} < 32'(LEAVES);
  assign child      = {node_r[TREE_AW-2:0], alu_res.go_right};
  assign vs_waddr   = in_slot[LEVELS-1:0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-VALUE_W-1){1'b0}}, out_err_r, out_val_r};

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    clr_cnt_nxt   = clr_cnt_r;
    res_val_nxt   = res_val_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    tr_we         = 1'b0;
    tr_waddr      = node_r;
    tr_wdata      = alu_res.wr_data;
    tr_re         = 1'b0;
    tr_raddr      = node_r;
    vs_we         = 1'b0;
    vs_re         = 1'b0;
    vs_raddr      = child[LEVELS-1:0];
    alu_op        = OP_IDLE;

    unique case (state_r)
      S_CLR: begin
        // Zero one tree node per cycle.
        tr_we       = 1'b1;
        tr_waddr    = clr_cnt_r;
        tr_wdata    = '0;
        clr_cnt_nxt = clr_cnt_r + TREE_AW'(1);
        if (clr_cnt_r == TREE_AW'(TREE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_LOAD: begin
              if (slot_ok) begin
                vs_we     = 1'b1;
                node_nxt  = {1'b1, in_slot[LEVELS-1:0]};
                tr_re     = 1'b1;
                tr_raddr  = {1'b1, in_slot[LEVELS-1:0]};
                state_nxt = S_LCHK;
              end
            end
            CMD_REMOVE: begin
              k_nxt     = in_rank;
              node_nxt  = TREE_AW'(1);
              tr_re     = 1'b1;
              tr_raddr  = TREE_AW'(1);
              state_nxt = S_RROOT;
            end
            CMD_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = S_CLR;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LCHK, S_LINC: begin
        // A present leaf on load leaves the counts alone.
        if (state_r == S_LCHK && tr_rdata != '0) begin
          state_nxt = S_IDLE;
        end else begin
          alu_op = OP_INC;
          tr_we  = 1'b1;
          if (node_r == TREE_AW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            tr_re     = 1'b1;
            tr_raddr  = node_r >> 1;
            node_nxt  = node_r >> 1;
            state_nxt = S_LINC;
          end
        end
      end
      S_RROOT: begin
        alu_op = OP_ROOT;
        if (alu_res.err) begin
          res_val_nxt = '0;
          res_err_nxt = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          // Decrement the root now; descent decrements each chosen child.
          tr_we     = 1'b1;
          cnt_nxt   = alu_res.child_cnt;
          tr_re     = 1'b1;
          tr_raddr  = TREE_AW'(2);
          state_nxt = S_DESC;
        end
      end
      S_DESC: begin
        alu_op   = OP_DESC;
        tr_we    = 1'b1;
        tr_waddr = child;
        node_nxt = child;
        cnt_nxt  = alu_res.child_cnt;
        k_nxt    = alu_res.k_nxt;
        if (child[TREE_AW-1]) begin
          vs_re     = 1'b1;
          state_nxt = S_VAL;
        end else begin
          tr_re    = 1'b1;
          tr_raddr = {child[TREE_AW-2:0], 1'b0};
        end
      end
      S_VAL: begin
        res_val_nxt = vs_rdata;
        res_err_nxt = 1'b0;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_err_nxt   = res_err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        clr_cnt_nxt = '0;
        state_nxt   = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    cnt_r     <= cnt_nxt;
    k_r       <= k_nxt;
    res_val_r <= res_val_nxt;
    res_err_r <= res_err_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

endmodule

[rtl/kpr_checker.sv]
// Port-level checker for the present-slot order-statistic store, bound to the top level.
// Depends on kpr_pkg and kth_present_remove_tree.
module kpr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [kpr_pkg::IN_W-1:0]  in_tdata,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [kpr_pkg::OUT_W-1:0] out_tdata
);
  import kpr_pkg::*;

  // A stalled result keeps its valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Every real command keeps the block busy for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] != CMD_NONE) |=> !in_tready)
    else $error("command accepted without busy period");

  // An error result carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[VALUE_W] |-> out_tdata[VALUE_W-1:0] == '0)
    else $error("error result with nonzero value");

endmodule

bind kth_present_remove_tree kpr_checker u_kpr_checker (.*);
